### rtl/fsi_pkg.sv
package fsi_pkg;

	// Defaults for the top-level parameters.
	localparam int INDEX_WIDTH_DEF    = 48;
	localparam int FEISTEL_ROUNDS_DEF = 6;

	// Mixer constants.
	localparam logic [63:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] MIX_MUL_A    = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [63:0] MIX_MUL_B    = 64'h94d0_49bb_1331_11eb;
	localparam int          SHIFT_A      = 30;
	localparam int          SHIFT_B      = 27;
	localparam int          SHIFT_C      = 31;

	// The round number is tagged into the round input at this bit.
	localparam int ROUND_TAG_SHIFT = 48;

	// Half width of the Feistel network is capped at one 32-bit word.
	localparam int HALF_MAX = 32;
	localparam int HALF_W   = 6;
	localparam int BITS_W   = 7;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_COUNT   = 2'd0,
		REG_SHUFFLE_SEED   = 2'd1,
		REG_SHUFFLE_ENABLE = 2'd2
	} cfg_reg_t;

	// Status of the half-width unit.
	typedef struct packed {
		logic              ready;
		logic [HALF_W-1:0] half;
	} hw_stat_t;

endpackage

### rtl/fsi_mix.sv
module fsi_mix (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] din,
	output logic        done,
	output logic [63:0] dout
);
	import fsi_pkg::*;

	typedef enum logic [4:0] {
		M_IDLE = 5'b00001,
		M_P0   = 5'b00010,
		M_P1   = 5'b00100,
		M_P2   = 5'b01000,
		M_P3   = 5'b10000
	} mstate_t;

	mstate_t     state_q;
	logic        pass_q;
	logic        done_q;
	logic [63:0] a_q;
	logic [63:0] pp_q;
	logic [63:0] acc_q;
	logic [63:0] res_q;

	logic [63:0] seeded;
	logic [63:0] prod;
	logic [63:0] coef;
	logic [31:0] op_a;
	logic [31:0] op_c;
	logic [63:0] mul_out;

	// The first pass multiplies by one constant, the second pass by the other.
	assign coef   = pass_q ? MIX_MUL_B : MIX_MUL_A;
	assign seeded = din + GOLDEN_GAMMA;

	// Low 64 bits of a 64x64 product from three 32x32 partial products.
	assign prod = acc_q + {pp_q[31:0], 32'b0};

	always_comb begin
		unique case (state_q)
			M_P1: begin
				op_a = a_q[31:0];
				op_c = coef[63:32];
			end
			M_P2: begin
				op_a = a_q[63:32];
				op_c = coef[31:0];
			end
			default: begin
				op_a = a_q[31:0];
				op_c = coef[31:0];
			end
		endcase
	end

	// The one shared multiplier, registered at its output.
	assign mul_out = {32'b0, op_a} * {32'b0, op_c};

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			pass_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						pass_q  <= 1'b0;
						state_q <= M_P0;
					end
				end
				M_P0: state_q <= M_P1;
				M_P1: state_q <= M_P2;
				M_P2: state_q <= M_P3;
				M_P3: begin
					if (!pass_q) begin
						pass_q  <= 1'b1;
						state_q <= M_P0;
					end else begin
						done_q  <= 1'b1;
						state_q <= M_IDLE;
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		pp_q <= mul_out;
		if (start && state_q == M_IDLE) begin
			a_q <= seeded ^ (seeded >> SHIFT_A);
		end else if (state_q == M_P3 && !pass_q) begin
			a_q <= prod ^ (prod >> SHIFT_B);
		end
		if (state_q == M_P1) begin
			acc_q <= pp_q;
		end else if (state_q == M_P2) begin
			acc_q <= prod;
		end
		if (state_q == M_P3 && pass_q) begin
			res_q <= prod ^ (prod >> SHIFT_C);
		end
	end

	assign done = done_q;
	assign dout = res_q;

endmodule

### rtl/fsi_hwidth.sv
module fsi_hwidth #(
	parameter int INDEX_WIDTH = fsi_pkg::INDEX_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [INDEX_WIDTH-1:0] nm1,
	output fsi_pkg::hw_stat_t      stat
);
	import fsi_pkg::*;

	localparam int LG     = (INDEX_WIDTH > 1) ? $clog2(INDEX_WIDTH) : 1;
	localparam int STEP_W = (LG > 1) ? $clog2(LG) : 1;

	logic                   run_q;
	logic                   ready_q;
	logic [STEP_W-1:0]      step_q;
	logic [INDEX_WIDTH-1:0] v_q;
	logic [BITS_W-1:0]      b_q;
	logic [HALF_W-1:0]      half_q;

	logic [BITS_W-1:0]      sh;
	logic [INDEX_WIDTH-1:0] v_sh;
	logic [INDEX_WIDTH-1:0] v_nx;
	logic [BITS_W-1:0]      b_nx;
	logic [BITS_W-1:0]      bits;
	logic [BITS_W-1:0]      half_raw;
	logic [HALF_W-1:0]      half_nx;

	// One binary-search step of the bit length of n-1 per cycle.
	assign sh   = BITS_W'(1) << step_q;
	assign v_sh = v_q >> sh;

	always_comb begin
		if (v_sh != '0) begin
			v_nx = v_sh;
			b_nx = b_q + sh;
		end else begin
			v_nx = v_q;
			b_nx = b_q;
		end
	end

	// Half width is the rounded-up half of the bit length, capped.
	assign bits     = b_nx + BITS_W'(v_nx[0]);
	assign half_raw = BITS_W'(bits + BITS_W'(1)) >> 1;
	assign half_nx  = (half_raw > BITS_W'(HALF_MAX)) ? HALF_W'(HALF_MAX)
	                                                 : half_raw[HALF_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			ready_q <= 1'b0;
			step_q  <= '0;
		end else if (start) begin
			run_q   <= 1'b1;
			ready_q <= 1'b0;
			step_q  <= STEP_W'(LG - 1);
		end else if (run_q) begin
			if (step_q == '0) begin
				run_q   <= 1'b0;
				ready_q <= 1'b1;
			end else begin
				step_q <= step_q - STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= nm1;
			b_q <= '0;
		end else if (run_q) begin
			v_q <= v_nx;
			b_q <= b_nx;
			if (step_q == '0) begin
				half_q <= half_nx;
			end
		end
	end

	assign stat.ready = ready_q;
	assign stat.half  = half_q;

endmodule

### rtl/feistel_shuffle_index.sv
// Shuffled sample index: maps an epoch number and a position to a sample index.
// Start channel: an item (epoch_number, position) is taken at a clock edge with
// start high and busy low. Each item gives exactly one result, shown for one
// cycle with done high on sample_index and position_error. The receiver cannot
// stall, so the result must be taken in that cycle.
// Configuration: cfg_we, cfg_index and cfg_data write sample_count (0),
// shuffle_seed (1) and shuffle_enable (2). The user must write them only while
// idle; the block does not enforce it. Index 3 is ignored.
// Direct results: a position out of range, disabled shuffling and a sample count of
// one give the result in the cycle after start, with busy staying low.
// Otherwise the block stays busy until the result, which shows in the first
// cycle with busy low. The shared 32x32 multiplier in the mixer does every mix:
// two for the key, then one per Feistel round, each after an issue state; each
// cycle-walk pass ends in one range check.
// Reset: sample_count is 1, shuffle_seed 0, shuffle_enable 1; no result pending.
module feistel_shuffle_index #(
	parameter int INDEX_WIDTH    = fsi_pkg::INDEX_WIDTH_DEF,
	parameter int FEISTEL_ROUNDS = fsi_pkg::FEISTEL_ROUNDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [31:0]                  epoch_number,
	input  logic [INDEX_WIDTH-1:0]       position,
	output logic                         done,
	output logic [INDEX_WIDTH-1:0]       sample_index,
	output logic                         position_error,
	input  logic                         cfg_we,
	input  logic [fsi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                  cfg_data
);
	import fsi_pkg::*;

	localparam int RW = (FEISTEL_ROUNDS > 1) ? $clog2(FEISTEL_ROUNDS) : 1;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_KEYA   = 6'b000010,
		S_KEYB   = 6'b000100,
		S_RSTART = 6'b001000,
		S_RWAIT  = 6'b010000,
		S_WALK   = 6'b100000
	} state_t;

	state_t                 state_q;
	logic [INDEX_WIDTH-1:0] n_q;
	logic [63:0]            seed_q;
	logic                   en_q;
	logic [INDEX_WIDTH-1:0] pos_q;
	logic [63:0]            key_q;
	logic [63:0]            rk_q;
	logic [31:0]            lo_q;
	logic [31:0]            hi_q;
	logic [RW-1:0]          r_q;
	logic                   done_q;
	logic [INDEX_WIDTH-1:0] idx_q;
	logic                   err_q;

	logic                   accept;
	logic                   pos_bad;
	logic                   trivial;
	logic                   need_shuffle;
	logic                   mix_start;
	logic [63:0]            mix_in;
	logic                   mix_done;
	logic [63:0]            mix_res;
	hw_stat_t               hw;
	logic [31:0]            hmask;
	logic [63:0]            pos_wide;
	logic [31:0]            split_lo;
	logic [31:0]            split_hi;
	logic [63:0]            joined;
	logic                   in_range;
	logic [31:0]            f_masked;
	logic [63:0]            round_in;
	logic                   last_round;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= INDEX_WIDTH'(1);
			seed_q <= '0;
			en_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLE_COUNT:   n_q    <= cfg_data[INDEX_WIDTH-1:0];
				REG_SHUFFLE_SEED:   seed_q <= cfg_data;
				REG_SHUFFLE_ENABLE: en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Item intake and the cases that need no rounds.
	assign accept       = start && (state_q == S_IDLE);
	assign pos_bad      = position >= n_q;
	assign trivial      = !en_q || (n_q == INDEX_WIDTH'(1));
	assign need_shuffle = accept && !pos_bad && !trivial;

	// Half-width mask and the split and join of the Feistel halves.
	assign hmask    = ~(32'hffff_ffff << hw.half);
	assign pos_wide = 64'(pos_q);
	assign split_lo = pos_wide[31:0] & hmask;
	assign split_hi = 32'(pos_wide >> hw.half) & hmask;
	assign joined   = ({32'b0, hi_q} << hw.half) | {32'b0, lo_q};
	assign in_range = joined < 64'(n_q);

	// Round function input and output.
	assign f_masked   = mix_res[31:0] & hmask;
	assign round_in   = {32'b0, lo_q} ^ rk_q ^ (64'(r_q) << ROUND_TAG_SHIFT);
	assign last_round = r_q == RW'(FEISTEL_ROUNDS - 1);

	// Feeds of the shared mixer.
	always_comb begin
		unique case (state_q)
			S_IDLE: begin
				mix_start = need_shuffle;
				mix_in    = {32'b0, epoch_number};
			end
			S_KEYA: begin
				mix_start = mix_done;
				mix_in    = seed_q ^ mix_res;
			end
			S_RSTART: begin
				mix_start = 1'b1;
				mix_in    = round_in;
			end
			default: begin
				mix_start = 1'b0;
				mix_in    = round_in;
			end
		endcase
	end

	fsi_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mix_start),
		.din    (mix_in),
		.done   (mix_done),
		.dout   (mix_res)
	);

	fsi_hwidth #(
		.INDEX_WIDTH (INDEX_WIDTH)
	) u_hwidth (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (need_shuffle),
		.nm1    (n_q - INDEX_WIDTH'(1)),
		.stat   (hw)
	);

	// Sequencer: direct results, key derivation, rounds and the cycle-walk check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			r_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (pos_bad || trivial) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_KEYA;
						end
					end
				end
				S_KEYA: begin
					if (mix_done) begin
						state_q <= S_KEYB;
					end
				end
				S_KEYB: begin
					if (mix_done) begin
						r_q     <= '0;
						state_q <= S_RSTART;
					end
				end
				S_RSTART: state_q <= S_RWAIT;
				S_RWAIT: begin
					if (mix_done) begin
						if (last_round) begin
							state_q <= S_WALK;
						end else begin
							r_q     <= r_q + RW'(1);
							state_q <= S_RSTART;
						end
					end
				end
				S_WALK: begin
					if (in_range) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						r_q     <= '0;
						state_q <= S_RSTART;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q <= position;
			if (pos_bad) begin
				idx_q <= '0;
				err_q <= 1'b1;
			end else begin
				idx_q <= en_q ? '0 : position;
				err_q <= 1'b0;
			end
		end
		if (state_q == S_KEYB && mix_done) begin
			key_q <= mix_res;
			rk_q  <= mix_res + GOLDEN_GAMMA;
			lo_q  <= split_lo;
			hi_q  <= split_hi;
		end
		if (state_q == S_RWAIT && mix_done) begin
			hi_q <= lo_q;
			lo_q <= (hi_q ^ f_masked) & hmask;
			rk_q <= rk_q + GOLDEN_GAMMA;
		end
		if (state_q == S_WALK) begin
			if (in_range) begin
				idx_q <= joined[INDEX_WIDTH-1:0];
				err_q <= 1'b0;
			end else begin
				rk_q <= key_q + GOLDEN_GAMMA;
			end
		end
	end

	assign busy           = state_q != S_IDLE;
	assign done           = done_q;
	assign sample_index   = idx_q;
	assign position_error = err_q;

	// The mixer reports a finished mix only while the sequencer waits for one.
	assert property (@(posedge clk) disable iff (!arst_n)
		mix_done |-> (state_q == S_KEYA || state_q == S_KEYB || state_q == S_RWAIT))
		else $error("mixer result outside a waiting state");

	// The half width is settled before the halves are split.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_KEYB && mix_done) |-> hw.ready)
		else $error("half width not ready at key completion");

	// Both halves stay within the half width.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (((lo_q & ~hmask) == '0) && ((hi_q & ~hmask) == '0)))
		else $error("Feistel half exceeds its width");

	// A position outside the domain gives a flagged zero on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pos_bad) |=> (done && position_error && sample_index == '0))
		else $error("out-of-range position not flagged");

endmodule

### tb/sv/tb.sv
module tb;
	import fsi_pkg::*;

	localparam int IW             = INDEX_WIDTH_DEF;
	localparam int ROUNDS         = FEISTEL_ROUNDS_DEF;
	localparam int STALL_LIMIT    = 20000;
	localparam int DRAIN_CYCLES   = 200;
	localparam int PHASES         = 20;
	localparam int ITEMS_PER_PH   = 100;
	localparam int QUIET_PHASES   = 3;
	localparam logic [1:0] REG_NONE = 2'd3;

	// Splitmix64 constants for the local index predictor.
	localparam logic [63:0] GAMMA = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] MUL_A = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [63:0] MUL_B = 64'h94d0_49bb_1331_11eb;

	typedef struct packed {
		logic [IW-1:0] sample_index;
		logic          position_error;
	} index_result_t;

	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_PRED,
		ROW_FIXED
	} row_kind_t;

	typedef struct packed {
		row_kind_t     kind;
		logic [1:0]    reg_idx;
		logic [63:0]   data;
		logic [31:0]   epoch;
		logic [IW-1:0] pos;
		logic [IW-1:0] want_index;
		logic          want_err;
	} stim_row_t;

	localparam int DIR_ROWS = 26;

	// Directed part: register writes and items; fixed rows carry their result.
	stim_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{ROW_FIXED, REG_NONE, 64'h0, 32'h0, 48'h0, 48'h0, 1'b0},
		'{ROW_FIXED, REG_NONE, 64'h0, 32'hffff_ffff, 48'h1, 48'h0, 1'b1},
		'{ROW_FIXED, REG_NONE, 64'h0, 32'h0, 48'hffff_ffff_ffff, 48'h0, 1'b1},
		'{ROW_WRITE, REG_NONE, 64'hffff_ffff_ffff_ffff, 32'h0, 48'h0, 48'h0, 1'b0},
		'{ROW_FIXED, REG_NONE, 64'h0, 32'hffff_ffff, 48'h0, 48'h0, 1'b0},
		'{ROW_WRITE, REG_SAMPLE_COUNT, 64'hffff_0000_0000_000a, 32'h0, 48'h0, 48'h0, 1'b0},
		'{ROW_WRITE, REG_SHUFFLE_SEED, 64'hffff_ffff_ffff_ffff, 32'h0, 48'h0, 48'h0, 1'b0},
		'{ROW_PRED, REG_NONE, 64'h0, 32'h0, 48'h0, 48'h0, 1'b0},
		'{ROW_PRED, REG_NONE, 64'h0, 32'hffff_ffff, 48'h9, 48'h0, 1'b0},
		'{ROW_FIXED, REG_NONE, 64'h0, 32'h5, 48'ha, 48'h0, 1'b1},
		'{ROW_WRITE, REG_SHUFFLE_ENABLE, 64'h0, 32'h0, 48'h0, 48'h0, 1'b0},
		'{ROW_FIXED, REG_NONE, 64'h0, 32'h3, 48'h7, 48'h7, 1'b0},
		'{ROW_FIXED, REG_NONE, 64'h0, 32'h3, 48'ha, 48'h0, 1'b1},
		'{ROW_WRITE, REG_SHUFFLE_ENABLE, 64'h2, 32'h0, 48'h0, 48'h0, 1'b0},
		'{ROW_FIXED, REG_NONE, 64'h0, 32'h9, 48'h3, 48'h3, 1'b0},
		'{ROW_WRITE, REG_SHUFFLE_ENABLE, 64'hffff_ffff_ffff_ffff, 32'h0, 48'h0, 48'h0, 1'b0},
		'{ROW_WRITE, REG_SAMPLE_COUNT, 64'h0, 32'h0, 48'h0, 48'h0, 1'b0},
		'{ROW_FIXED, REG_NONE, 64'h0, 32'h0, 48'h0, 48'h0, 1'b1},
		'{ROW_WRITE, REG_SAMPLE_COUNT, 64'h0000_ffff_ffff_ffff, 32'h0, 48'h0, 48'h0, 1'b0},
		'{ROW_WRITE, REG_SHUFFLE_SEED, 64'h0, 32'h0, 48'h0, 48'h0, 1'b0},
		'{ROW_PRED, REG_NONE, 64'h0, 32'hffff_ffff, 48'hffff_ffff_fffe, 48'h0, 1'b0},
		'{ROW_FIXED, REG_NONE, 64'h0, 32'h0, 48'hffff_ffff_ffff, 48'h0, 1'b1},
		'{ROW_PRED, REG_NONE, 64'h0, 32'h0, 48'h0, 48'h0, 1'b0},
		'{ROW_WRITE, REG_SAMPLE_COUNT, 64'h2, 32'h0, 48'h0, 48'h0, 1'b0},
		'{ROW_PRED, REG_NONE, 64'h0, 32'h1, 48'h1, 48'h0, 1'b0},
		'{ROW_PRED, REG_NONE, 64'h0, 32'h0, 48'h0, 48'h0, 1'b0}
	};

	logic          clk            = 1'b0;
	logic          arst_n         = 1'b0;
	logic          start          = 1'b0;
	logic [31:0]   epoch_number   = '0;
	logic [IW-1:0] position       = '0;
	logic          cfg_we         = 1'b0;
	logic [1:0]    cfg_index      = '0;
	logic [63:0]   cfg_data       = '0;
	logic          busy;
	logic          done;
	logic [IW-1:0] sample_index;
	logic          position_error;

	// Local copy of the configuration registers.
	logic [IW-1:0] count_reg  = 48'd1;
	logic [63:0]   seed_reg   = 64'd0;
	logic          enable_reg = 1'b1;

	index_result_t pending_index_q [$];
	int unsigned   mismatches   = 0;
	int unsigned   stall_cycles = 0;

	feistel_shuffle_index u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.epoch_number  (epoch_number),
		.position      (position),
		.done          (done),
		.sample_index  (sample_index),
		.position_error(position_error),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// Splitmix64 finalizer.
	function automatic logic [63:0] splitmix(input logic [63:0] v);
		v = v + GAMMA;
		v = (v ^ (v >> 30)) * MUL_A;
		v = (v ^ (v >> 27)) * MUL_B;
		return v ^ (v >> 31);
	endfunction

	// Predicts the sample index for one item under the current registers.
	function automatic index_result_t shuffle_lookup(input logic [31:0] epoch,
			input logic [IW-1:0] pos);
		index_result_t res;
		logic [63:0]   key;
		logic [63:0]   hmask;
		logic [63:0]   lo;
		logic [63:0]   hi;
		logic [63:0]   nlo;
		logic [63:0]   f;
		logic [63:0]   v;
		logic [63:0]   span;
		int unsigned   bits;
		int unsigned   h;
		int            r;
		res = '0;
		if (pos >= count_reg) begin
			res.position_error = 1'b1;
		end else if (!enable_reg) begin
			res.sample_index = pos;
		end else if (count_reg != 48'd1) begin
			// Half width follows from the bit count of sample_count - 1.
			bits = 0;
			span = 64'(count_reg) - 64'd1;
			while (span != 0) begin
				bits++;
				span = span >> 1;
			end
			h = (bits + 1) / 2;
			if (h > 32)
				h = 32;
			hmask = (64'd1 << h) - 64'd1;
			key = splitmix(seed_reg ^ splitmix({32'd0, epoch}));
			v = 64'(pos);
			// Cycle-walk the Feistel network until the value is in range.
			do begin
				lo = v & hmask;
				hi = (v >> h) & hmask;
				for (r = 0; r < ROUNDS; r++) begin
					f = splitmix(lo ^ (key + GAMMA * 64'(r + 1)) ^ (64'(r) << 48)) & hmask;
					nlo = (hi ^ f) & hmask;
					hi = lo;
					lo = nlo;
				end
				v = (hi << h) | lo;
			end while (v >= 64'(count_reg));
			res.sample_index = v[IW-1:0];
		end
		return res;
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH at %0t: %s: got %h, expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Compare each result item against the oldest expectation.
	always @(posedge clk) begin : check_results
		index_result_t want;
		if (arst_n && done) begin
			if (pending_index_q.size() == 0) begin
				note_mismatch("result with none pending", 64'(sample_index), 64'd0);
			end else begin
				want = pending_index_q.pop_front();
				if (sample_index !== want.sample_index)
					note_mismatch("sample_index", 64'(sample_index), 64'(want.sample_index));
				if (position_error !== want.position_error)
					note_mismatch("position_error", 64'(position_error),
						64'(want.position_error));
			end
		end
	end

	// Watchdog on cycles in which nothing moves.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Present one item and hold it until accepted; start stays high afterwards.
	task automatic put_item(input logic [31:0] epoch, input logic [IW-1:0] pos,
			input index_result_t want);
		start        <= 1'b1;
		cfg_we       <= 1'b0;
		epoch_number <= epoch;
		position     <= pos;
		do
			@(posedge clk);
		while (busy);
		pending_index_q.push_back(want);
	endtask

	// Drop start and wait until every result is in and the block is idle.
	task automatic wait_idle();
		start  <= 1'b0;
		cfg_we <= 1'b0;
		do
			@(negedge clk);
		while (pending_index_q.size() != 0 || busy);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_SAMPLE_COUNT:   count_reg  = data[IW-1:0];
			REG_SHUFFLE_SEED:   seed_reg   = data;
			REG_SHUFFLE_ENABLE: enable_reg = data[0];
			default: ;
		endcase
	endtask

	initial begin
		index_result_t want;
		logic [IW-1:0] n;
		logic [IW-1:0] pos;
		logic [31:0]   epoch;
		logic [63:0]   en_data;
		row_kind_t     last_kind;
		int            i;
		int            ph;
		int            k;
		int            sel;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		last_kind = ROW_WRITE;
		for (i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				if (last_kind != ROW_WRITE || i == 0)
					wait_idle();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].data);
			end else begin
				if (dir_rows[i].kind == ROW_FIXED) begin
					want.sample_index   = dir_rows[i].want_index;
					want.position_error = dir_rows[i].want_err;
				end else begin
					want = shuffle_lookup(dir_rows[i].epoch, dir_rows[i].pos);
				end
				put_item(dir_rows[i].epoch, dir_rows[i].pos, want);
			end
			last_kind = dir_rows[i].kind;
		end

		// Random phases, each with a fresh configuration.
		for (ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_NONE, {$urandom, $urandom});
			case ($urandom_range(0, 6))
				0:       n = 48'($urandom_range(1, 16));
				1:       n = 48'($urandom_range(2, 5000));
				2:       n = {16'($urandom), 32'($urandom)};
				3:       n = '1;
				4:       n = 48'd1 << $urandom_range(1, 47);
				5:       n = (48'd1 << $urandom_range(1, 46)) + 48'd1;
				default: n = 48'($urandom_range(0, 1));
			endcase
			write_reg(REG_SAMPLE_COUNT, {16'($urandom), n});
			write_reg(REG_SHUFFLE_SEED, {$urandom, $urandom});
			en_data = {$urandom, $urandom};
			en_data[0] = ($urandom_range(0, 4) != 0);
			write_reg(REG_SHUFFLE_ENABLE, en_data);

			for (k = 0; k < ITEMS_PER_PH; k++) begin
				// Sender gaps, none in the closing phases.
				if (ph < PHASES - QUIET_PHASES && $urandom_range(0, 2) == 0) begin
					start  <= 1'b0;
					cfg_we <= 1'b0;
					repeat ($urandom_range(1, 7)) @(posedge clk);
				end
				epoch = ($urandom_range(0, 15) == 0) ? 32'($urandom_range(0, 1)) * 32'hffff_ffff
					: 32'($urandom);
				sel = $urandom_range(0, 9);
				if (count_reg != 0 && sel < 8)
					pos = IW'({$urandom, $urandom} % 64'(count_reg));
				else if (sel == 8)
					pos = count_reg;
				else
					pos = {16'($urandom), 32'($urandom)};
				put_item(epoch, pos, shuffle_lookup(epoch, pos));
			end
		end

		// Drain and watch for stray results.
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### sim.f
rtl/fsi_pkg.sv
rtl/fsi_mix.sv
rtl/fsi_hwidth.sv
rtl/feistel_shuffle_index.sv
tb/sv/tb.sv
